// ----- rtl/ising_ring_spin_update_unit_macros.svh -----
// Assertion macros shared by the ring spin update unit.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ISING_RING_SPIN_UPDATE_UNIT_MACROS_SVH
`define ISING_RING_SPIN_UPDATE_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ISRU_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ISRU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ISRU_ASSERT(lbl, ante, cons)
`define ISRU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/isru_pkg.sv -----
`default_nettype none

package isru_pkg;

    // Fixed field widths of the item, result and configuration transactions.
    localparam int SITE_W  = 6;
    localparam int RAND_W  = 16;
    localparam int COUNT_W = 7;
    localparam int SUM_W   = 8;
    localparam int CFG_IDX_W = 3;

    // Operation codes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Update modes.
    localparam logic MODE_GIBBS = 1'b0;
    localparam logic MODE_METRO = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_5   = 3'd7;

    // Weight table: entries 0..2 for an up spin or in Gibbs mode, 3..5 for a down spin in Metropolis mode.
    localparam int NUM_WEIGHTS = 6;
    localparam logic [CFG_IDX_W-1:0] W_DOWN_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] W_DOWN_TOP  = 3'd5;

    // Control of the ring accumulator.
    typedef struct packed {
        logic clear;
        logic step;
        logic first;
        logic close;
    } isru_acc_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/isru_item_if.sv -----
`default_nettype none

interface isru_item_if;
    import isru_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [SITE_W-1:0] site;
    logic              spin_up;
    logic [RAND_W-1:0] random_fraction;

    modport source (output valid, output operation, output site, output spin_up,
                    output random_fraction, input ready);
    modport sink (input valid, input operation, input site, input spin_up,
                  input random_fraction, output ready);
endinterface

`default_nettype wire

// ----- rtl/isru_result_if.sv -----
`default_nettype none

interface isru_result_if;
    import isru_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    spin_after;
    logic                    flipped;
    logic signed [SUM_W-1:0] magnetization;
    logic signed [SUM_W-1:0] bond_sum;
    logic                    site_error;

    modport source (output valid, output spin_after, output flipped,
                    output magnetization, output bond_sum, output site_error,
                    input ready);
    modport sink (input valid, input spin_after, input flipped, input magnetization,
                  input bond_sum, input site_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/isru_cfg_if.sv -----
`default_nettype none

// DATA_W must be at least PROB_BITS + 1 of the unit that sinks it.
interface isru_cfg_if #(
    parameter int DATA_W = 17
);
    import isru_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/isru_spin_ram.sv -----
`default_nettype none

// Single-bit spin store: one write port, one read port with registered data.
module isru_spin_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic          wdata,
    input  wire logic [AW-1:0] raddr,
    output logic               rdata
);
    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

// ----- rtl/isru_ring_acc.sv -----
`default_nettype none

// Accumulates magnetization and bond sum from spins presented in ring order.
// The closing step adds the bond between the last spin and the first one.
module isru_ring_acc #(
    parameter int SW = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  isru_pkg::isru_acc_ctl_t    ctl,
    input  wire logic                  spin,
    output logic signed [SW-1:0]       mag,
    output logic signed [SW-1:0]       bond
);
    import isru_pkg::*;

    logic signed [SW-1:0] mag_reg;
    logic signed [SW-1:0] bond_reg;
    logic                 first_spin_reg;
    logic                 prev_spin_reg;
    logic                 bond_en;
    logic                 bond_same;

    // At most one bond term per cycle: either with the previous spin or the closing one.
    assign bond_en   = (ctl.step && !ctl.first) || ctl.close;
    assign bond_same = ctl.close ? (prev_spin_reg == first_spin_reg)
                                 : (prev_spin_reg == spin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg        <= '0;
            bond_reg       <= '0;
            first_spin_reg <= 1'b1;
            prev_spin_reg  <= 1'b1;
        end
        else if (ctl.clear)
        begin
            mag_reg  <= '0;
            bond_reg <= '0;
        end
        else
        begin
            if (ctl.step)
            begin
                mag_reg       <= spin ? mag_reg + SW'(1) : mag_reg - SW'(1);
                prev_spin_reg <= spin;
                if (ctl.first)
                begin
                    first_spin_reg <= spin;
                end
            end
            if (bond_en)
            begin
                bond_reg <= bond_same ? bond_reg + SW'(1) : bond_reg - SW'(1);
            end
        end
    end

    assign mag  = mag_reg;
    assign bond = bond_reg;
endmodule

`default_nettype wire

// ----- rtl/ising_ring_spin_update_unit.sv -----
`default_nettype none
// Ring spin update unit: a periodic ring of up to MAX_SPINS Ising spins.
// The item channel carries load transactions (set one spin) and update
// transactions (Metropolis flip or Gibbs heat-bath at one site, decided by
// comparing random_fraction against a weight register). Each accepted item
// yields exactly one transaction on the result channel with the spin at the
// site, whether it flipped, and the magnetization and bond sum of the ring.
// The configuration channel is always ready; write it only while idle.
// The spin store has one read port, so the neighbor fetch and the walk
// over all n spins of the ring for the sums take one read per cycle, and
// that walk sets the time from one acceptance to the next. An out-of-ring
// site skips the fetch and the update and goes straight to the walk.
// After reset a clearing pass writes every spin to +1; no item is
// accepted during it. A result waits in an output register; a new item
// can be worked on meanwhile, and the unit holds its finished sums
// until the receiver takes the pending result.
`include "ising_ring_spin_update_unit_macros.svh"

module ising_ring_spin_update_unit #(
    parameter int MAX_SPINS = 64,
    parameter int PROB_BITS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    isru_item_if.sink       item,
    isru_result_if.source   result,
    isru_cfg_if.sink        cfg
);
    import isru_pkg::*;

    localparam int AW  = (MAX_SPINS > 1) ? $clog2(MAX_SPINS) : 1;
    localparam int NB  = $clog2(MAX_SPINS + 1);
    // Counter and ring size width: holds MAX_SPINS and any spin_count value.
    localparam int CW  = (NB > COUNT_W) ? NB : COUNT_W;
    // Accumulator width: holds +-MAX_SPINS and the saturation limits.
    localparam int SW  = (NB + 1 > SUM_W) ? NB + 1 : SUM_W;
    localparam int RW  = (PROB_BITS > RAND_W) ? PROB_BITS : RAND_W;
    localparam int WW  = PROB_BITS + 1;
    localparam logic [WW-1:0] WEIGHT_ONE = {1'b1, {PROB_BITS{1'b0}}};
    localparam logic signed [SW-1:0] SAT_HI = SW'(127);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-128);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_FETCH  = 6'b000100,
        S_UPDATE = 6'b001000,
        S_WALK   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic               mode_reg;
    logic [COUNT_W-1:0] spin_count_reg;
    logic [WW-1:0]      weight_reg [NUM_WEIGHTS];

    // Item held while it is worked on.
    logic                 op_reg;
    logic [SITE_W-1:0]    site_reg;
    logic                 up_reg;
    logic [PROB_BITS-1:0] rand_reg;
    logic                 err_reg, err_next;
    logic                 left_reg, left_next;
    logic                 right_reg, right_next;
    logic                 after_reg, after_next;
    logic                 flip_reg, flip_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic                 rd_first_reg, rd_first_next;

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    logic                    out_after_reg;
    logic                    out_flip_reg;
    logic signed [SUM_W-1:0] out_mag_reg;
    logic signed [SUM_W-1:0] out_bond_reg;
    logic                    out_err_reg;
    logic                    out_load;

    logic                 accept;
    logic [CW-1:0]        ring_n;
    logic [CW-1:0]        count_ext;
    logic [CW-1:0]        site_ext;
    logic [CW-1:0]        item_site_ext;
    logic [CW-1:0]        left_ext;
    logic [CW-1:0]        right_ext;
    logic [RW-1:0]        rand_ext;
    logic [1:0]           sum_idx;
    logic [CFG_IDX_W-1:0] widx;
    logic                 hit;
    logic                 old_spin;
    logic                 new_spin;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    isru_acc_ctl_t        acc_ctl;
    logic signed [SW-1:0] acc_mag;
    logic signed [SW-1:0] acc_bond;
    logic signed [SW-1:0] mag_sat;
    logic signed [SW-1:0] bond_sat;

    // ---------------------------------------------------------------------
    // Configuration writes. The channel never stalls.
    // ---------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_METRO;
            spin_count_reg <= COUNT_W'(50);
            for (int i = 0; i < NUM_WEIGHTS; i++)
            begin
                weight_reg[i] <= WEIGHT_ONE;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.index) inside
                CFG_MODE:
                begin
                    mode_reg <= cfg.data[0];
                end
                CFG_SPIN_COUNT:
                begin
                    spin_count_reg <= cfg.data[COUNT_W-1:0];
                end
                [CFG_WEIGHT_0:CFG_WEIGHT_5]:
                begin
                    weight_reg[cfg.index - CFG_WEIGHT_0] <= cfg.data[WW-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Ring geometry. The ring size saturates at MAX_SPINS; neighbors wrap.
    // ---------------------------------------------------------------------
    assign count_ext     = CW'(spin_count_reg);
    assign ring_n        = (count_ext > CW'(MAX_SPINS)) ? CW'(MAX_SPINS) : count_ext;
    assign site_ext      = CW'(site_reg);
    assign item_site_ext = CW'(item.site);
    assign left_ext      = (site_ext == '0) ? ring_n - CW'(1) : site_ext - CW'(1);
    assign right_ext     = (site_ext + CW'(1) == ring_n) ? '0 : site_ext + CW'(1);

    assign rand_ext = RW'(item.random_fraction);
    assign accept   = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);

    // ---------------------------------------------------------------------
    // Update decision. The neighbor sum index is 0, 1, 2 for sums of
    // -2, 0, +2. A down spin in Metropolis mode mirrors it into the upper
    // half of the weight table, since k is then the negated sum.
    // ---------------------------------------------------------------------
    assign old_spin = ram_rdata;
    assign sum_idx  = {left_reg & right_reg, left_reg ^ right_reg};

    always_comb
    begin
        if (mode_reg == MODE_METRO && !old_spin)
        begin
            widx = W_DOWN_TOP - CFG_IDX_W'(sum_idx);
        end
        else
        begin
            widx = CFG_IDX_W'(sum_idx);
        end
    end

    assign hit = {1'b0, rand_reg} < weight_reg[widx];

    always_comb
    begin
        if (op_reg == OP_LOAD)
        begin
            new_spin = up_reg;
        end
        else if (mode_reg == MODE_METRO)
        begin
            new_spin = hit ? !old_spin : old_spin;
        end
        else
        begin
            new_spin = hit;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        err_next      = err_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        after_next    = after_reg;
        flip_next     = flip_reg;
        rd_vld_next   = 1'b0;
        rd_first_next = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg[AW-1:0];
        ram_wdata     = 1'b1;
        ram_raddr     = cnt_reg[AW-1:0];
        out_load      = 1'b0;
        acc_ctl       = '0;

        case (state_reg)
            S_CLEAR:
            begin
                // Reset sweep: every stored spin becomes +1.
                ram_we = 1'b1;
                if (cnt_reg == CW'(MAX_SPINS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    acc_ctl.clear = 1'b1;
                    cnt_next      = '0;
                    after_next    = 1'b0;
                    flip_next     = 1'b0;
                    err_next      = item_site_ext >= ring_n;
                    state_next    = (item_site_ext >= ring_n) ? S_WALK : S_FETCH;
                end
            end
            S_FETCH:
            begin
                // Reads of left, right and the site itself, one per cycle.
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        ram_raddr = left_ext[AW-1:0];
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    2'd1:
                    begin
                        ram_raddr = right_ext[AW-1:0];
                        left_next = ram_rdata;
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    default:
                    begin
                        ram_raddr  = site_ext[AW-1:0];
                        right_next = ram_rdata;
                        cnt_next   = '0;
                        state_next = S_UPDATE;
                    end
                endcase
            end
            S_UPDATE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = site_ext[AW-1:0];
                ram_wdata  = new_spin;
                after_next = new_spin;
                flip_next  = new_spin != old_spin;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // One read per cycle in ring order; the data reach the
                // accumulator in the next cycle, then one closing step.
                acc_ctl.step  = rd_vld_reg;
                acc_ctl.first = rd_first_reg;
                if (cnt_reg < ring_n)
                begin
                    rd_vld_next   = 1'b1;
                    rd_first_next = (cnt_reg == '0);
                    cnt_next      = cnt_reg + CW'(1);
                end
                else if (!rd_vld_reg)
                begin
                    acc_ctl.close = (ring_n != '0);
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= rd_vld_next;
            rd_first_reg <= rd_first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        after_reg <= after_next;
        flip_reg  <= flip_next;
        if (accept)
        begin
            op_reg   <= item.operation;
            site_reg <= item.site;
            up_reg   <= item.spin_up;
            rand_reg <= rand_ext[PROB_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Spin store and the shared ring accumulator.
    // ---------------------------------------------------------------------
    isru_spin_ram #(
        .DEPTH (MAX_SPINS),
        .AW    (AW)
    ) u_spin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    isru_ring_acc #(
        .SW (SW)
    ) u_ring_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (acc_ctl),
        .spin  (ram_rdata),
        .mag   (acc_mag),
        .bond  (acc_bond)
    );

    // Sums only leave eight bits for rings longer than 127 spins.
    assign mag_sat  = (acc_mag > SAT_HI) ? SAT_HI : ((acc_mag < SAT_LO) ? SAT_LO : acc_mag);
    assign bond_sat = (acc_bond > SAT_HI) ? SAT_HI
                                          : ((acc_bond < SAT_LO) ? SAT_LO : acc_bond);

    // ---------------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_after_reg <= after_reg;
            out_flip_reg  <= flip_reg;
            out_mag_reg   <= mag_sat[SUM_W-1:0];
            out_bond_reg  <= bond_sat[SUM_W-1:0];
            out_err_reg   <= err_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.spin_after    = out_after_reg;
    assign result.flipped       = out_flip_reg;
    assign result.magnetization = out_mag_reg;
    assign result.bond_sum      = out_bond_reg;
    assign result.site_error    = out_err_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    `ISRU_ASSERT_NEXT(a_busy_after_accept, item.valid && item.ready, !item.ready)
    `ISRU_ASSERT(a_ram_write_phase, ram_we, (state_reg == S_CLEAR) || (state_reg == S_UPDATE))
    `ISRU_ASSERT(a_error_keeps_spin, result.valid && result.site_error, !result.spin_after && !result.flipped)
    `ISRU_ASSERT(a_result_from_finish, $rose(result.valid), $past(state_reg) == S_FINISH)
endmodule

`default_nettype wire
